// ===== rtl/lsc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsc_pkg: lever sample conditioner shared definitions
// Widths, fixed-point constants, register indexes, FSM states and the
// mouse-path status record.
// ----------------------------------------------------------------------------
package lsc_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int CFG_BITS      = SAMPLE_BITS;
  localparam int POS_BITS      = 16;
  localparam int NUM_BITS      = SAMPLE_BITS + POS_BITS;
  localparam int AXIS_BITS     = 25;
  localparam int AXIS_OUT_BITS = 16;
  localparam int MAG_BITS      = 24;
  localparam int WEIGHT_BITS   = 7;
  localparam int DIV_BITS      = MAG_BITS + WEIGHT_BITS;
  localparam int CNT_BITS      = 5;
  localparam int ACC_BITS      = 29;
  localparam int ACC_INT_BITS  = ACC_BITS - 16;
  localparam int STEP_BITS     = 8;
  localparam int GAIN_BITS     = 11;
  localparam int SCALED_BITS   = POS_BITS + GAIN_BITS;

  localparam logic [SAMPLE_BITS-1:0] SPAN_MARGIN   = SAMPLE_BITS'(50);
  localparam logic [SAMPLE_BITS-1:0] FALLBACK_LOW  = SAMPLE_BITS'(50);
  localparam logic [SAMPLE_BITS-1:0] FALLBACK_HIGH = SAMPLE_BITS'(2**SAMPLE_BITS - 51);
  localparam logic [SAMPLE_BITS-1:0] FILTER_RESET  = SAMPLE_BITS'(2**(SAMPLE_BITS-1));

  localparam logic [POS_BITS:0]              POS_FULL    = (POS_BITS+1)'(65535);
  localparam logic signed [AXIS_BITS-1:0]    AXIS_OFFSET = AXIS_BITS'(32767 * 256);
  localparam logic [WEIGHT_BITS-1:0]         WEIGHT_MAX  = WEIGHT_BITS'(100);
  localparam logic [WEIGHT_BITS-1:0]         DIVISOR     = WEIGHT_BITS'(100);

  localparam logic [GAIN_BITS-1:0]           MOUSE_GAIN  = GAIN_BITS'(2000);
  localparam logic [POS_BITS-1:0]            POS_HALF    = POS_BITS'(32768);
  localparam logic signed [ACC_BITS-1:0]     ACC_MAX     = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0]     ACC_MIN     = {1'b1, {(ACC_BITS-1){1'b0}}};
  localparam logic signed [ACC_INT_BITS-1:0] STEP_HI     = ACC_INT_BITS'(127);
  localparam logic signed [ACC_INT_BITS-1:0] STEP_LO     = -ACC_INT_BITS'(127);

  typedef enum logic [1:0] {
    REG_SPAN_LOW,
    REG_SPAN_HIGH,
    REG_AXIS_INVERT,
    REG_AXIS_SMOOTHING
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOAD,
    ST_POS,
    ST_TGT,
    ST_SUB,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                        busy;
    logic signed [STEP_BITS-1:0] step;
  } mouse_status_t;

endpackage

// ===== rtl/lever_sample_conditioner_top.sv =====
// ----------------------------------------------------------------------------
// lever_sample_conditioner_top: analog lever conditioner
// Quarter-weight low-pass filter, calibrated span scaling, smoothed gamepad
// axis and accumulated mouse delta.
//
// Usage: one raw sample is taken per in beat (in_valid/in_ready); each gives
// exactly one result beat (out_valid/out_ready) carrying the filtered level,
// the 16-bit position, the gamepad axis and the mouse delta. Registers are
// written through cfg_we/cfg_index/cfg_data; the user must write them only
// while no sample is in flight, as the block itself does not enforce it.
// The position divide and the smoothing divide by 100 are bit-serial, one
// quotient bit at a time; the smoothing divide is skipped when the axis is
// direct. in_ready is high only between samples, so the block takes no new
// sample before it is through with the last one. The result sits in an
// output register; the next sample is taken while it waits. A stalled
// receiver holds the block once the following result is finished. Reset
// restores the calibration, clears the axis and mouse state and sets the
// filter to mid-scale; no result is pending after reset.
// ----------------------------------------------------------------------------
module lever_sample_conditioner_top import lsc_pkg::*; (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [CFG_BITS-1:0]             cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [SAMPLE_BITS-1:0]          raw_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [SAMPLE_BITS-1:0]          filtered_level,
  output logic [POS_BITS-1:0]             io4_position,
  output logic signed [AXIS_OUT_BITS-1:0] gamepad_axis,
  output logic signed [STEP_BITS-1:0]     mouse_delta
);

  state_t state, state_next;

  logic [SAMPLE_BITS-1:0]          span_low;
  logic [SAMPLE_BITS-1:0]          span_high;
  logic                            axis_invert;
  logic [7:0]                      axis_smoothing;
  logic [SAMPLE_BITS-1:0]          filter_value;
  logic signed [AXIS_BITS-1:0]     axis_smoothed;

  logic [SAMPLE_BITS-1:0]          lvl_off;
  logic [SAMPLE_BITS-1:0]          den;
  logic [SAMPLE_BITS-1:0]          rem;
  logic [POS_BITS-1:0]             quo;
  logic [CNT_BITS-1:0]             cnt;
  logic signed [AXIS_BITS-1:0]     target;
  logic [WEIGHT_BITS-1:0]          weight;
  logic                            direct;
  logic [MAG_BITS-1:0]             mag;
  logic                            mag_neg;
  logic [DIV_BITS-1:0]             dsh;
  logic [WEIGHT_BITS-1:0]          drem;

  logic                            mouse_start;
  logic                            out_load;
  mouse_status_t                   mstat;

  logic [SAMPLE_BITS+1:0]          filter_sum;
  logic [SAMPLE_BITS:0]            span_lim;
  logic                            narrow;
  logic [SAMPLE_BITS-1:0]          lo;
  logic [SAMPLE_BITS-1:0]          hi;
  logic [SAMPLE_BITS-1:0]          level;
  logic [NUM_BITS-1:0]             num;
  logic [SAMPLE_BITS:0]            rem_sh;
  logic                            pos_ge;
  logic [SAMPLE_BITS:0]            rem_sub;
  logic [POS_BITS-1:0]             pi;
  logic [POS_BITS:0]               c_sum;
  logic                            c_ge;
  logic                            c_rnz;
  logic [8:0]                      ceil_c;
  logic signed [AXIS_BITS-1:0]     target_next;
  logic [WEIGHT_BITS-1:0]          weight_next;
  logic [MAG_BITS-1:0]             mag_next;
  logic [DIV_BITS-1:0]             prod;
  logic [WEIGHT_BITS:0]            div_sh;
  logic                            div_ge;
  logic [WEIGHT_BITS:0]            div_sub;
  logic signed [AXIS_BITS-1:0]     q_s;
  logic signed [AXIS_BITS-1:0]     smooth_next;
  logic signed [AXIS_BITS-1:0]     axis_round;

  lsc_mouse u_mouse (
    .clk      (clk),
    .rst      (rst),
    .start    (mouse_start),
    .position (quo),
    .status   (mstat)
  );

  // datapath
  always_comb begin
    filter_sum = {1'b0, filter_value, 1'b0} + {2'b0, filter_value} + {2'b0, raw_sample};

    span_lim = {1'b0, span_low} + {1'b0, SPAN_MARGIN};
    narrow   = {1'b0, span_high} <= span_lim;
    lo       = narrow ? FALLBACK_LOW : span_low;
    hi       = narrow ? FALLBACK_HIGH : span_high;
    if (filter_value < lo) begin
      level = lo;
    end else if (filter_value > hi) begin
      level = hi;
    end else begin
      level = filter_value;
    end

    num = {lvl_off, {POS_BITS{1'b0}}} - NUM_BITS'(lvl_off);

    rem_sh  = {rem, quo[POS_BITS-1]};
    rem_sub = rem_sh - {1'b0, den};
    pos_ge  = rem_sh >= {1'b0, den};

    // T = 256 * Pi - ceil(256 * Pi / 65535) - offset
    pi     = axis_invert ? ~quo : quo;
    c_sum  = (POS_BITS+1)'(pi[15:8]) + {1'b0, pi[7:0], 8'd0};
    c_ge   = c_sum >= POS_FULL;
    c_rnz  = c_ge ? (c_sum != POS_FULL) : (c_sum != '0);
    ceil_c = {1'b0, pi[15:8]} + 9'(c_ge) + 9'(c_rnz);
    target_next = $signed({1'b0, pi, 8'd0}) - $signed(AXIS_BITS'(ceil_c)) - AXIS_OFFSET;

    weight_next = (axis_smoothing > 8'(WEIGHT_MAX)) ? WEIGHT_MAX : axis_smoothing[6:0];

    mag_next = (target < axis_smoothed) ? MAG_BITS'(axis_smoothed - target)
                                        : MAG_BITS'(target - axis_smoothed);
    prod = {{WEIGHT_BITS{1'b0}}, mag} * {{MAG_BITS{1'b0}}, weight};

    div_sh  = {drem, dsh[DIV_BITS-1]};
    div_sub = div_sh - {1'b0, DIVISOR};
    div_ge  = div_sh >= {1'b0, DIVISOR};

    q_s = $signed(dsh[AXIS_BITS-1:0]);
    if (direct) begin
      smooth_next = target;
    end else if (mag_neg) begin
      smooth_next = axis_smoothed - q_s;
    end else begin
      smooth_next = axis_smoothed + q_s;
    end

    axis_round = axis_smoothed[AXIS_BITS-1] ? axis_smoothed + AXIS_BITS'(255) : axis_smoothed;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_PREP;
      ST_PREP: state_next = ST_LOAD;
      ST_LOAD: state_next = ST_POS;
      ST_POS:  if (cnt == '0) state_next = ST_TGT;
      ST_TGT:  state_next = ST_SUB;
      ST_SUB:  state_next = ST_MUL;
      ST_MUL:  state_next = direct ? ST_FIN : ST_DIV;
      ST_DIV:  if (cnt == '0) state_next = ST_FIN;
      ST_FIN:  state_next = ST_OUT;
      ST_OUT:  if ((!out_valid || out_ready) && !mstat.busy) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready    = 1'b0;
    mouse_start = 1'b0;
    out_load    = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_TGT:  mouse_start = 1'b1;
      ST_OUT:  out_load = (!out_valid || out_ready) && !mstat.busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      span_low       <= FALLBACK_LOW;
      span_high      <= FALLBACK_HIGH;
      axis_invert    <= 1'b0;
      axis_smoothing <= '0;
      filter_value   <= FILTER_RESET;
      axis_smoothed  <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_SPAN_LOW:       span_low <= cfg_data[SAMPLE_BITS-1:0];
          REG_SPAN_HIGH:      span_high <= cfg_data[SAMPLE_BITS-1:0];
          REG_AXIS_INVERT:    axis_invert <= cfg_data[0];
          REG_AXIS_SMOOTHING: axis_smoothing <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        filter_value <= filter_sum[SAMPLE_BITS+1:2];
      end
      if (state == ST_FIN) begin
        axis_smoothed <= smooth_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_PREP: begin
        lvl_off <= level - lo;
        den     <= hi - lo;
      end
      ST_LOAD: begin
        rem <= num[NUM_BITS-1:POS_BITS];
        quo <= num[POS_BITS-1:0];
        cnt <= CNT_BITS'(POS_BITS - 1);
      end
      ST_POS: begin
        rem <= pos_ge ? rem_sub[SAMPLE_BITS-1:0] : rem_sh[SAMPLE_BITS-1:0];
        quo <= {quo[POS_BITS-2:0], pos_ge};
        cnt <= cnt - 1'b1;
      end
      ST_TGT: begin
        target <= target_next;
        weight <= weight_next;
        direct <= (weight_next <= WEIGHT_BITS'(1)) || (weight_next == WEIGHT_MAX);
      end
      ST_SUB: begin
        mag     <= mag_next;
        mag_neg <= target < axis_smoothed;
      end
      ST_MUL: begin
        dsh  <= prod;
        drem <= '0;
        cnt  <= CNT_BITS'(DIV_BITS - 1);
      end
      ST_DIV: begin
        drem <= div_ge ? div_sub[WEIGHT_BITS-1:0] : div_sh[WEIGHT_BITS-1:0];
        dsh  <= {dsh[DIV_BITS-2:0], div_ge};
        cnt  <= cnt - 1'b1;
      end
      default: ;
    endcase
    if (out_load) begin
      filtered_level <= filter_value;
      io4_position   <= quo;
      gamepad_axis   <= axis_round[AXIS_OUT_BITS+7:8];
      mouse_delta    <= mstat.step;
    end
  end

  a_mouse_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mstat.busy)
    else $error("mouse path still busy between samples");

  a_pos_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POS) |-> (rem < den))
    else $error("position divide remainder out of range");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (drem < DIVISOR))
    else $error("smoothing divide remainder out of range");

  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |-> (axis_smoothed <= AXIS_OFFSET) && (axis_smoothed >= -AXIS_OFFSET))
    else $error("axis state outside target range");

endmodule

// ===== rtl/lsc_mouse.sv =====
// ----------------------------------------------------------------------------
// lsc_mouse: mouse delta path
// Scales the position change into a Q.16 accumulator, saturates it and
// takes whole steps of at most 127 counts out of it, once per start pulse.
// ----------------------------------------------------------------------------
module lsc_mouse import lsc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [POS_BITS-1:0] position,
  output mouse_status_t       status
);

  logic [POS_BITS-1:0]             prev;
  logic signed [POS_BITS:0]        diff;
  logic                            neg;
  logic [SCALED_BITS-1:0]          scaled;
  logic signed [ACC_BITS-1:0]      dval;
  logic signed [ACC_BITS-1:0]      acc;
  logic [3:0]                      stg;
  logic signed [STEP_BITS-1:0]     step;

  logic [POS_BITS-1:0]             diff_neg;
  logic [POS_BITS-1:0]             diff_mag;
  logic [SCALED_BITS-1:0]          scaled_next;
  logic [POS_BITS:0]               sc_sum;
  logic                            sc_carry;
  logic [ACC_BITS-2:0]             dmag;
  logic signed [ACC_BITS-1:0]      dval_next;
  logic signed [ACC_BITS:0]        acc_sum;
  logic signed [ACC_BITS-1:0]      acc_sat;
  logic signed [ACC_INT_BITS-1:0]  acc_hi;
  logic signed [ACC_INT_BITS-1:0]  step_raw;
  logic signed [ACC_INT_BITS-1:0]  step_lim;
  logic signed [ACC_INT_BITS-1:0]  acc_hi_next;

  always_comb begin
    diff_neg    = POS_BITS'(-diff);
    diff_mag    = diff[POS_BITS] ? diff_neg : diff[POS_BITS-1:0];
    scaled_next = {{GAIN_BITS{1'b0}}, diff_mag} * {{POS_BITS{1'b0}}, MOUSE_GAIN};

    // x * 65536 / 65535 = x + x / 65535, quotient by one fold and compare
    sc_sum   = (POS_BITS+1)'(scaled[SCALED_BITS-1:POS_BITS]) + {1'b0, scaled[POS_BITS-1:0]};
    sc_carry = sc_sum >= POS_FULL;
    dmag     = (ACC_BITS-1)'(scaled) + (ACC_BITS-1)'(scaled[SCALED_BITS-1:POS_BITS])
             + (ACC_BITS-1)'(sc_carry);
    dval_next = neg ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});

    acc_sum = {acc[ACC_BITS-1], acc} + {dval[ACC_BITS-1], dval};
    if (acc_sum[ACC_BITS] != acc_sum[ACC_BITS-1]) begin
      acc_sat = acc_sum[ACC_BITS] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_sat = acc_sum[ACC_BITS-1:0];
    end

    // truncate toward zero
    acc_hi   = acc[ACC_BITS-1:16];
    step_raw = acc_hi + ACC_INT_BITS'(acc[ACC_BITS-1] && (acc[15:0] != 16'd0));
    if (step_raw > STEP_HI) begin
      step_lim = STEP_HI;
    end else if (step_raw < STEP_LO) begin
      step_lim = STEP_LO;
    end else begin
      step_lim = step_raw;
    end
    acc_hi_next = acc_hi - step_lim;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= POS_HALF;
      acc  <= '0;
      stg  <= '0;
    end else begin
      stg <= {stg[2:0], start};
      if (start) begin
        prev <= position;
      end
      if (stg[2]) begin
        acc <= acc_sat;
      end else if (stg[3]) begin
        acc <= {acc_hi_next, acc[15:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      diff <= $signed({1'b0, position}) - $signed({1'b0, prev});
    end
    if (stg[0]) begin
      neg    <= diff[POS_BITS];
      scaled <= scaled_next;
    end
    if (stg[1]) begin
      dval <= dval_next;
    end
    if (stg[3]) begin
      step <= STEP_BITS'(step_lim);
    end
  end

  assign status.busy = |stg;
  assign status.step = step;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !status.busy)
    else $error("mouse start while busy");

  a_one_stage: assert property (@(posedge clk) disable iff (rst)
    $onehot0(stg))
    else $error("mouse stages overlap");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    stg[3] |=> (step <= 8'sd127) && (step >= -8'sd127))
    else $error("mouse step out of range");

endmodule
